FILE: hw/rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared helpers for the concurrent checks in the frame averaging RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle implication failed");

// Next-cycle implication, checked at every rising edge outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle implication failed");

`endif

FILE: hw/rtl/fma_pkg.sv
// ---------------------------------------------------------------------------
// Frame moving average package
// Sizes, register indexes and the controller/datapath interface types.
// ---------------------------------------------------------------------------
package fma_pkg;

  localparam int MAX_DEPTH      = 16;
  localparam int MAX_FRAME_LEN  = 1024;
  localparam int SAMPLE_BITS    = 16;

  localparam int SLOT_BITS      = $clog2(MAX_DEPTH);
  localparam int POS_BITS       = $clog2(MAX_FRAME_LEN);
  localparam int DEPTH_BITS     = $clog2(MAX_DEPTH + 1);
  localparam int SUM_BITS       = SAMPLE_BITS + SLOT_BITS;
  localparam int CNT_BITS       = $clog2(SUM_BITS);
  localparam int FS_WORDS       = MAX_DEPTH * MAX_FRAME_LEN;

  localparam int CFG_DEPTH_BITS = 5;
  localparam int CFG_LEN_BITS   = 11;
  localparam int CFG_DATA_BITS  = 11;
  localparam int CFG_INDEX_BITS = 2;

  localparam logic [CFG_INDEX_BITS-1:0] REG_DEPTH  = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_LENGTH = 2'd1;

  localparam logic [CFG_DEPTH_BITS-1:0] DEPTH_RESET = 5'd1;
  localparam logic [CFG_LEN_BITS-1:0]   LEN_RESET   = 11'd1024;

  typedef struct packed {
    logic capture;
    logic upd;
    logic div_step;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic need_div;
    logic div_last;
    logic out_full;
  } status_t;

endpackage

FILE: hw/rtl/fma_ram.sv
// ---------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ---------------------------------------------------------------------------
module fma_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: hw/rtl/fma_ctrl.sv
// ---------------------------------------------------------------------------
// Frame moving average controller
// Sequences capture, store update, division (averaged beats only) and output load for each beat.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module fma_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  fma_pkg::status_t status,
  output fma_pkg::cmd_t    cmd
);

  import fma_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_UPD  = 3'd1;
  localparam logic [2:0] S_DIV  = 3'd2;
  localparam logic [2:0] S_OUT  = 3'd3;

  logic [2:0] state_r;
  logic [2:0] state_nxt;
  logic       accept;

  assign in_tready = (state_r == S_IDLE);
  assign accept    = in_tvalid && in_tready;

  always_comb begin
    state_nxt    = state_r;
    cmd          = '0;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          cmd.capture = 1'b1;
          state_nxt   = S_UPD;
        end
      end
      S_UPD: begin
        cmd.upd   = 1'b1;
        state_nxt = status.need_div ? S_DIV : S_OUT;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_last) begin
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (!status.out_full) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  `ASSERT_NEXT(a_accept_to_upd, clk, rst_n, accept, state_r == S_UPD)
  `ASSERT_NEXT(a_div_exit, clk, rst_n, state_r == S_DIV, state_r == S_DIV || state_r == S_OUT)
  `ASSERT_IMPL(a_load_when_free, clk, rst_n, cmd.out_load, !status.out_full)

endmodule

FILE: hw/rtl/fma_dpath.sv
// ---------------------------------------------------------------------------
// Frame moving average datapath
// Configuration, pointers, frame store, running sums, divider and output beat.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module fma_dpath (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [fma_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  logic [fma_pkg::CFG_DATA_BITS-1:0]   cfg_wdata,
  input  logic [fma_pkg::SAMPLE_BITS-1:0]     in_tdata,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [fma_pkg::SAMPLE_BITS-1:0]     out_tdata,
  output logic                                out_tlast,
  output logic                                out_tuser,
  input  fma_pkg::cmd_t                       cmd,
  output fma_pkg::status_t                    status
);

  import fma_pkg::*;

  logic [CFG_DEPTH_BITS-1:0]      depth_cfg_r;
  logic [CFG_LEN_BITS-1:0]        len_cfg_r;
  logic [DEPTH_BITS-1:0]          depth_eff;
  logic [DEPTH_BITS-1:0]          depth_m1;
  logic [POS_BITS-1:0]            len_m1;
  logic                           bypass;
  logic                           clear;

  logic [SLOT_BITS-1:0]           slot_r;
  logic [POS_BITS-1:0]            pos_r;
  logic                           window_full_r;
  logic                           last;
  logic                           slot_top;
  logic                           full_now;

  logic signed [SAMPLE_BITS-1:0]  sample_r;
  logic [SLOT_BITS+POS_BITS-1:0]  fs_addr;
  logic [SAMPLE_BITS-1:0]         fs_rdata;
  logic [SUM_BITS-1:0]            rs_rdata;
  logic                           mem_we;
  logic signed [SAMPLE_BITS-1:0]  old_smp;
  logic signed [SUM_BITS-1:0]     base_sum;
  logic signed [SUM_BITS-1:0]     new_sum;
  logic [SUM_BITS-1:0]            mag;

  logic [DEPTH_BITS-1:0]          rem_r;
  logic [SUM_BITS-1:0]            quo_r;
  logic [CNT_BITS-1:0]            cnt_r;
  logic                           neg_r;
  logic                           use_div_r;
  logic                           last_r;
  logic                           avg_r;
  logic [DEPTH_BITS:0]            trial;
  logic                           ge;
  logic [DEPTH_BITS-1:0]          rem_nxt;
  logic [SUM_BITS-1:0]            quo_nxt;
  logic [SUM_BITS-1:0]            quo_signed;
  logic [SAMPLE_BITS-1:0]         result;

  logic                           out_valid_r;
  logic [SAMPLE_BITS-1:0]         out_data_r;
  logic                           out_last_r;
  logic                           out_avg_r;

  assign clear = cfg_we && ((cfg_index == REG_DEPTH) || (cfg_index == REG_LENGTH));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      depth_cfg_r <= DEPTH_RESET;
      len_cfg_r   <= LEN_RESET;
    end else if (cfg_we) begin
      if (cfg_index == REG_DEPTH) begin
        depth_cfg_r <= cfg_wdata[CFG_DEPTH_BITS-1:0];
      end
      if (cfg_index == REG_LENGTH) begin
        len_cfg_r <= cfg_wdata[CFG_LEN_BITS-1:0];
      end
    end
  end

  always_comb begin
    if (depth_cfg_r == '0) begin
      depth_eff = DEPTH_BITS'(1);
    end else if (depth_cfg_r > CFG_DEPTH_BITS'(MAX_DEPTH)) begin
      depth_eff = DEPTH_BITS'(MAX_DEPTH);
    end else begin
      depth_eff = DEPTH_BITS'(depth_cfg_r);
    end
    if (len_cfg_r == '0) begin
      len_m1 = '0;
    end else if (len_cfg_r > CFG_LEN_BITS'(MAX_FRAME_LEN)) begin
      len_m1 = POS_BITS'(MAX_FRAME_LEN - 1);
    end else begin
      len_m1 = POS_BITS'(len_cfg_r - CFG_LEN_BITS'(1));
    end
  end

  assign depth_m1 = depth_eff - DEPTH_BITS'(1);
  assign bypass   = (depth_eff == DEPTH_BITS'(1));
  assign last     = (pos_r == len_m1);
  assign slot_top = (slot_r == SLOT_BITS'(depth_m1));
  assign full_now = window_full_r || slot_top;

  always_ff @(posedge clk) begin
    if (!rst_n || clear) begin
      slot_r        <= '0;
      pos_r         <= '0;
      window_full_r <= 1'b0;
    end else if (cmd.upd) begin
      if (last) begin
        pos_r <= '0;
        if (!bypass) begin
          if (slot_top) begin
            slot_r        <= '0;
            window_full_r <= 1'b1;
          end else begin
            slot_r <= slot_r + SLOT_BITS'(1);
          end
        end
      end else begin
        pos_r <= pos_r + POS_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      sample_r <= in_tdata;
    end
  end

  assign fs_addr = {slot_r, pos_r};
  assign mem_we  = cmd.upd && !bypass;

  fma_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (FS_WORDS)
  ) u_frame_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (fs_addr),
    .wdata (sample_r),
    .re    (cmd.capture),
    .raddr (fs_addr),
    .rdata (fs_rdata)
  );

  fma_ram #(
    .WIDTH (SUM_BITS),
    .DEPTH (MAX_FRAME_LEN)
  ) u_running_sum (
    .clk   (clk),
    .we    (mem_we),
    .waddr (pos_r),
    .wdata (new_sum),
    .re    (cmd.capture),
    .raddr (pos_r),
    .rdata (rs_rdata)
  );

  // Entries not yet written since the last clear read as zero: the frame
  // store slot only after the window has wrapped, a sum after the first frame.
  assign old_smp  = window_full_r ? $signed(fs_rdata) : '0;
  assign base_sum = (window_full_r || (slot_r != '0)) ? $signed(rs_rdata) : '0;
  assign new_sum  = base_sum + SUM_BITS'(sample_r) - SUM_BITS'(old_smp);
  assign mag      = new_sum[SUM_BITS-1] ? (SUM_BITS'(0) - $unsigned(new_sum))
                                        : $unsigned(new_sum);

  assign trial   = {rem_r, quo_r[SUM_BITS-1]};
  assign ge      = (trial >= {1'b0, depth_eff});
  assign rem_nxt = ge ? DEPTH_BITS'(trial - {1'b0, depth_eff}) : DEPTH_BITS'(trial);
  assign quo_nxt = {quo_r[SUM_BITS-2:0], ge};

  always_ff @(posedge clk) begin
    if (cmd.upd) begin
      rem_r     <= '0;
      quo_r     <= mag;
      cnt_r     <= '0;
      neg_r     <= new_sum[SUM_BITS-1];
      use_div_r <= !bypass && full_now;
      last_r    <= last;
      avg_r     <= bypass || full_now;
    end else if (cmd.div_step) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
      cnt_r <= cnt_r + CNT_BITS'(1);
    end
  end

  assign quo_signed = neg_r ? (SUM_BITS'(0) - quo_r) : quo_r;
  assign result     = use_div_r ? quo_signed[SAMPLE_BITS-1:0] : sample_r;

  assign status.need_div = !bypass && full_now;
  assign status.div_last = (cnt_r == CNT_BITS'(SUM_BITS - 1));
  assign status.out_full = out_valid_r && !out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data_r <= result;
      out_last_r <= last_r;
      out_avg_r  <= avg_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_avg_r;

  `ASSERT_IMPL(a_slot_range, clk, rst_n, 1'b1, DEPTH_BITS'(slot_r) < depth_eff)
  `ASSERT_IMPL(a_pos_range, clk, rst_n, 1'b1, pos_r <= len_m1)
  `ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid)

endmodule

FILE: hw/rtl/frame_moving_average.sv
// ---------------------------------------------------------------------------
// Frame moving average
// Position-by-position average of a sample stream over the last N frames.
// ---------------------------------------------------------------------------
// Input beats carry one signed 16-bit sample each on in_tdata. Output beats
// carry the result sample on out_tdata, the last position of the frame on
// out_tlast and the averaged flag on out_tuser.
// Register 0 sets the number of frames averaged (1 to 16), register 1 the
// frame length (1 to 1024). Any write to either clears the window. Reset
// returns the registers to a depth of one and a length of 1024.
// The stores are updated in the cycle after a beat is accepted. While the
// window fills, or with a depth of one, the result skips the divider and
// goes straight to the output register; the next beat is taken only once
// that result is loaded. Averaged beats run through a restoring divider
// that retires one quotient bit per cycle, and the next beat is likewise
// taken only once the quotient is loaded into the output register.
// The frame store and running sums sit in RAMs with one write port and one
// registered read port; reset needs no clearing pass, entries not written
// since the last clear read as zero. The output register holds a result
// until the receiver takes it; the next input beat is still accepted, and
// the input stalls only once that beat's result waits on a full register.
// ---------------------------------------------------------------------------
module frame_moving_average (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [fma_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [fma_pkg::CFG_DATA_BITS-1:0]  cfg_wdata,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [fma_pkg::SAMPLE_BITS-1:0]    in_tdata,   // [15:0] sample
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [fma_pkg::SAMPLE_BITS-1:0]    out_tdata,  // [15:0] result_sample
  output logic                               out_tlast,
  output logic                               out_tuser   // [0] is_averaged
);

  import fma_pkg::*;

  cmd_t    cmd;
  status_t status;

  fma_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .status    (status),
    .cmd       (cmd)
  );

  fma_dpath u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser),
    .cmd        (cmd),
    .status     (status)
  );

endmodule
